FILE: rtl/core/lsprs_pkg.sv
// package for the limited-slot priority request scheduler
// holds the transaction structs, action codes and default sizes
// no dependencies
package lsprs_pkg;

   localparam int PEND_DEPTH_DEFAULT = 16;
   localparam int ID_BITS_DEFAULT    = 8;
   localparam logic [7:0] SLOT_RESET = 8'd10;
   localparam int PCOUNT_BITS        = 5;
   localparam int PRIO_BITS          = 16;

   localparam logic [1:0] ACT_REQUEST  = 2'd0;
   localparam logic [1:0] ACT_COMPLETE = 2'd1;
   localparam logic [1:0] ACT_SETPRIO  = 2'd2;
   localparam logic [1:0] ACT_CANCEL   = 2'd3;

   typedef struct packed {
      logic [1:0]                  action;
      logic [7:0]                  resource_id;
      logic signed [PRIO_BITS-1:0] priority_req;
   } req_data_type;

   typedef struct packed {
      logic                   granted;
      logic [7:0]             grant_id;
      logic                   queued;
      logic                   dropped;
      logic [7:0]             free_count;
      logic [PCOUNT_BITS-1:0] pending_count;
   } rsp_data_type;

endpackage

FILE: rtl/core/lsprs_ram.sv
// generic simple dual-port ram with registered read
// one write port and one read port, read data valid in the cycle after rd_en
// no dependencies
module lsprs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/core/limited_slot_priority_request_scheduler.sv
// top level of the limited-slot priority request scheduler
// depends on lsprs_pkg and lsprs_ram

// Grants load requests while at most slot_limit are in flight. Waiting requests
// sit in a pending store of PEND_DEPTH entries (identifier, priority, recency
// rank) held in one ram with a single read port, and every pass over the store
// reads one entry per cycle, so that port sets the rate. A request granted from
// a free slot, a dropped request and a completion with nothing pending go
// straight to the result without a pass. A queued request and a set priority take
// one pass. A completion that grants a pending entry takes a search pass and a
// removal pass. A cancel takes one search pass plus one search and one removal
// pass per matching entry. One transaction is worked on at a time; the result
// register lets the next transaction be taken while a result waits. Writing
// slot_limit reloads the free slot count and leaves the pending store alone.
module limited_slot_priority_request_scheduler
   import lsprs_pkg::*;
#(
   parameter int PEND_DEPTH = PEND_DEPTH_DEFAULT,
   parameter int ID_BITS    = ID_BITS_DEFAULT
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  req_data_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_data_type rsp_data,
   input  logic         psel,
   input  logic         penable,
   input  logic         pwrite,
   input  logic [2:0]   paddr,
   input  logic [31:0]  pwdata,
   output logic [31:0]  prdata,
   output logic         pready
);

   localparam int SLOT_BITS = $clog2(PEND_DEPTH);
   localparam int CNT_BITS  = $clog2(PEND_DEPTH + 1);
   localparam int WORD_BITS = ID_BITS + PRIO_BITS + SLOT_BITS;
   localparam logic [SLOT_BITS-1:0] LAST_IDX = SLOT_BITS'(PEND_DEPTH - 1);
   localparam logic [CNT_BITS-1:0]  FULL_CNT = CNT_BITS'(PEND_DEPTH);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_SWEEP  = 2'd1;
   localparam logic [1:0] ST_FINISH = 2'd2;

   localparam logic [1:0] MODE_INSERT = 2'd0;
   localparam logic [1:0] MODE_PRIO   = 2'd1;
   localparam logic [1:0] MODE_FIND   = 2'd2;
   localparam logic [1:0] MODE_REMOVE = 2'd3;

   // control state
   logic [1:0]            state_ff, state_in;
   logic [1:0]            mode_ff, mode_in;
   logic [7:0]            limit_ff, limit_in;
   logic [7:0]            free_ff, free_in;
   logic [CNT_BITS-1:0]   cnt_ff, cnt_in;
   logic [PEND_DEPTH-1:0] valid_ff, valid_in;
   logic                  rd_on_ff, rd_on_in;
   logic                  pv_ff, pv_in;
   logic                  ins_done_ff, ins_done_in;
   logic                  best_valid_ff, best_valid_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   // payload
   logic [SLOT_BITS-1:0]  rd_idx_ff, rd_idx_in;
   logic [SLOT_BITS-1:0]  pidx_ff, pidx_in;
   logic [1:0]            act_ff, act_in;
   logic [ID_BITS-1:0]    id_ff, id_in;
   logic [PRIO_BITS-1:0]  prio_ff, prio_in;
   logic [SLOT_BITS-1:0]  best_idx_ff, best_idx_in;
   logic [PRIO_BITS-1:0]  best_prio_ff, best_prio_in;
   logic [SLOT_BITS-1:0]  best_stamp_ff, best_stamp_in;
   logic [ID_BITS-1:0]    best_ident_ff, best_ident_in;
   logic                  granted_ff, granted_in;
   logic [7:0]            gid_ff, gid_in;
   logic                  queued_ff, queued_in;
   logic                  dropped_ff, dropped_in;
   rsp_data_type          rsp_data_ff, rsp_data_in;

   // ram ports
   logic                  ram_we;
   logic [SLOT_BITS-1:0]  ram_waddr;
   logic [WORD_BITS-1:0]  ram_wdata;
   logic                  ram_re;
   logic [WORD_BITS-1:0]  ram_rdata;

   logic [SLOT_BITS-1:0]  r_stamp;
   logic [PRIO_BITS-1:0]  r_prio;
   logic [ID_BITS-1:0]    r_ident;
   logic                  r_vld;
   logic                  pass_end;
   logic                  cfg_wr;
   logic                  better;

   lsprs_ram #(
      .WIDTH (WORD_BITS),
      .DEPTH (PEND_DEPTH)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (rd_idx_ff),
      .rd_data (ram_rdata)
   );

   assign r_stamp  = ram_rdata[SLOT_BITS-1:0];
   assign r_prio   = ram_rdata[SLOT_BITS +: PRIO_BITS];
   assign r_ident  = ram_rdata[SLOT_BITS+PRIO_BITS +: ID_BITS];
   assign r_vld    = valid_ff[pidx_ff];
   assign pass_end = pv_ff && (pidx_ff == LAST_IDX);
   assign cfg_wr   = psel && penable && pwrite && !paddr[2];
   assign better   = !best_valid_ff || ($signed(r_prio) > $signed(best_prio_ff)) ||
                     ((r_prio == best_prio_ff) && (r_stamp < best_stamp_ff));

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign pready    = 1'b1;
   assign prdata    = paddr[2] ? 32'd0 : 32'(limit_ff);

   always_comb begin
      state_in      = state_ff;
      mode_in       = mode_ff;
      limit_in      = limit_ff;
      free_in       = free_ff;
      cnt_in        = cnt_ff;
      valid_in      = valid_ff;
      rd_on_in      = rd_on_ff;
      pv_in         = 1'b0;
      ins_done_in   = ins_done_ff;
      best_valid_in = best_valid_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rd_idx_in     = rd_idx_ff;
      pidx_in       = pidx_ff;
      act_in        = act_ff;
      id_in         = id_ff;
      prio_in       = prio_ff;
      best_idx_in   = best_idx_ff;
      best_prio_in  = best_prio_ff;
      best_stamp_in = best_stamp_ff;
      best_ident_in = best_ident_ff;
      granted_in    = granted_ff;
      gid_in        = gid_ff;
      queued_in     = queued_ff;
      dropped_in    = dropped_ff;
      rsp_data_in   = rsp_data_ff;
      ram_we        = 1'b0;
      ram_waddr     = pidx_ff;
      ram_wdata     = ram_rdata;
      ram_re        = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               act_in      = req_data.action;
               id_in       = ID_BITS'(req_data.resource_id);
               prio_in     = req_data.priority_req;
               granted_in  = 1'b0;
               gid_in      = 8'd0;
               queued_in   = 1'b0;
               dropped_in  = 1'b0;
               rd_idx_in   = '0;
               rd_on_in    = 1'b1;
               ins_done_in = 1'b0;
               best_valid_in = 1'b0;
               state_in    = ST_SWEEP;
               unique case (req_data.action)
                  ACT_REQUEST: begin
                     mode_in = MODE_INSERT;
                     if (free_ff != 8'd0) begin
                        free_in    = free_ff - 8'd1;
                        granted_in = 1'b1;
                        gid_in     = 8'(id_in);
                        state_in   = ST_FINISH;
                     end else if (cnt_ff == FULL_CNT) begin
                        dropped_in = 1'b1;
                        state_in   = ST_FINISH;
                     end
                  end
                  ACT_COMPLETE: begin
                     mode_in = MODE_FIND;
                     if (cnt_ff == '0) begin
                        if (free_ff != 8'hFF) begin
                           free_in = free_ff + 8'd1;
                        end
                        state_in = ST_FINISH;
                     end
                  end
                  ACT_SETPRIO: mode_in = MODE_PRIO;
                  default:     mode_in = MODE_FIND;
               endcase
            end
         end
         ST_SWEEP: begin
            if (rd_on_ff) begin
               ram_re  = 1'b1;
               pv_in   = 1'b1;
               pidx_in = rd_idx_ff;
               if (rd_idx_ff == LAST_IDX) begin
                  rd_on_in = 1'b0;
               end else begin
                  rd_idx_in = rd_idx_ff + SLOT_BITS'(1);
               end
            end
            if (pv_ff) begin
               unique case (mode_ff)
                  MODE_INSERT: begin
                     if (r_vld) begin
                        ram_we    = 1'b1;
                        ram_wdata = {r_ident, r_prio, r_stamp + SLOT_BITS'(1)};
                     end else if (!ins_done_ff) begin
                        ram_we            = 1'b1;
                        ram_wdata         = {id_ff, prio_ff, SLOT_BITS'(0)};
                        valid_in[pidx_ff] = 1'b1;
                        ins_done_in       = 1'b1;
                        cnt_in            = cnt_ff + CNT_BITS'(1);
                        queued_in         = 1'b1;
                     end
                     if (pass_end) begin
                        state_in = ST_FINISH;
                     end
                  end
                  MODE_PRIO: begin
                     if (r_vld && (r_ident == id_ff)) begin
                        ram_we    = 1'b1;
                        ram_wdata = {r_ident, prio_ff, r_stamp};
                     end
                     if (pass_end) begin
                        state_in = ST_FINISH;
                     end
                  end
                  MODE_FIND: begin
                     if (r_vld && (((act_ff == ACT_COMPLETE) && better) ||
                                   ((act_ff == ACT_CANCEL) && !best_valid_ff &&
                                    (r_ident == id_ff)))) begin
                        best_valid_in = 1'b1;
                        best_idx_in   = pidx_ff;
                        best_prio_in  = r_prio;
                        best_stamp_in = r_stamp;
                        best_ident_in = r_ident;
                     end
                     if (pass_end) begin
                        if (best_valid_in) begin
                           mode_in   = MODE_REMOVE;
                           rd_idx_in = '0;
                           rd_on_in  = 1'b1;
                        end else begin
                           state_in = ST_FINISH;
                        end
                     end
                  end
                  default: begin
                     if (pidx_ff == best_idx_ff) begin
                        valid_in[pidx_ff] = 1'b0;
                     end else if (r_vld && (r_stamp > best_stamp_ff)) begin
                        ram_we    = 1'b1;
                        ram_wdata = {r_ident, r_prio, r_stamp - SLOT_BITS'(1)};
                     end
                     if (pass_end) begin
                        cnt_in = cnt_ff - CNT_BITS'(1);
                        if (act_ff == ACT_COMPLETE) begin
                           granted_in = 1'b1;
                           gid_in     = 8'(best_ident_ff);
                           state_in   = ST_FINISH;
                        end else begin
                           mode_in       = MODE_FIND;
                           best_valid_in = 1'b0;
                           rd_idx_in     = '0;
                           rd_on_in      = 1'b1;
                        end
                     end
                  end
               endcase
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in              = 1'b1;
               rsp_data_in.granted       = granted_ff;
               rsp_data_in.grant_id      = gid_ff;
               rsp_data_in.queued        = queued_ff;
               rsp_data_in.dropped       = dropped_ff;
               rsp_data_in.free_count    = free_ff;
               rsp_data_in.pending_count = PCOUNT_BITS'(cnt_ff);
               state_in                  = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      if (cfg_wr) begin
         limit_in = pwdata[7:0];
         free_in  = pwdata[7:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         mode_ff       <= MODE_INSERT;
         limit_ff      <= SLOT_RESET;
         free_ff       <= SLOT_RESET;
         cnt_ff        <= '0;
         valid_ff      <= '0;
         rd_on_ff      <= 1'b0;
         pv_ff         <= 1'b0;
         ins_done_ff   <= 1'b0;
         best_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         mode_ff       <= mode_in;
         limit_ff      <= limit_in;
         free_ff       <= free_in;
         cnt_ff        <= cnt_in;
         valid_ff      <= valid_in;
         rd_on_ff      <= rd_on_in;
         pv_ff         <= pv_in;
         ins_done_ff   <= ins_done_in;
         best_valid_ff <= best_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_idx_ff     <= rd_idx_in;
      pidx_ff       <= pidx_in;
      act_ff        <= act_in;
      id_ff         <= id_in;
      prio_ff       <= prio_in;
      best_idx_ff   <= best_idx_in;
      best_prio_ff  <= best_prio_in;
      best_stamp_ff <= best_stamp_in;
      best_ident_ff <= best_ident_in;
      granted_ff    <= granted_in;
      gid_ff        <= gid_in;
      queued_ff     <= queued_in;
      dropped_ff    <= dropped_in;
      rsp_data_ff   <= rsp_data_in;
   end

endmodule

FILE: rtl/core/lsprs_checker.sv
// port-level checker for the limited-slot priority request scheduler
// depends on lsprs_pkg; bound to the top level at the end of this file
module lsprs_checker
   import lsprs_pkg::*;
(
   input logic         clock,
   input logic         reset,
   input logic         req_valid,
   input logic         req_ready,
   input logic         rsp_valid,
   input logic         rsp_ready,
   input rsp_data_type rsp_data
);

   // one transaction in flight at a time
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while a transaction is in flight");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

   a_drop_alone: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.dropped |-> !rsp_data.granted && !rsp_data.queued)
      else $error("dropped result also granted or queued");

   a_queue_no_slot: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.queued |-> !rsp_data.granted && (rsp_data.free_count == 8'd0))
      else $error("queued while a slot was free");

   a_idle_id: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.granted |-> rsp_data.grant_id == 8'd0)
      else $error("grant id set without a grant");

endmodule

bind limited_slot_priority_request_scheduler lsprs_checker u_lsprs_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
